// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, held off during reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check without reset qualification
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tor_pkg.sv =====
// ----------------------------------------------------------------------------
// tor_pkg
// Types and constants of the 2-opt route improver.
// ----------------------------------------------------------------------------
package tor_pkg;

    localparam int SHORT_ROUTE = 3;
    localparam int PASS_LIMIT  = 256;
    localparam int PASS_W      = $clog2(PASS_LIMIT + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK,
        ST_RP, ST_RA, ST_RB, ST_RQ,
        ST_DPA, ST_DBQ, ST_DPB, ST_DAQ, ST_CMP,
        ST_FRL, ST_FRH, ST_FWL, ST_FWH,
        ST_ADV, ST_OPRIME, ST_ORUN
    } state_t;

    typedef enum logic [2:0] {
        RA_PM1, RA_I, RA_J, RA_JP1, RA_LO, RA_HI, RA_ZERO, RA_K1
    } raddr_sel_t;

    typedef enum logic [1:0] {
        DA_PA, DA_BQ, DA_PB, DA_AQ
    } daddr_sel_t;

    typedef struct packed {
        logic       load_dist;
        logic       load_route;
        logic       init_pass;
        logic       next_j;
        logic       next_i;
        logic       next_pass;
        logic       cap_p;
        logic       cap_a;
        logic       cap_b;
        logic       cap_q;
        logic       now_first;
        logic       now_add;
        logic       alt_first;
        logic       set_flip;
        logic       cap_t;
        logic       wr_lo;
        logic       wr_hi_step;
        logic       out_init;
        logic       out_emit;
        raddr_sel_t rsel;
        daddr_sel_t dsel;
    } cmd_t;

    typedef struct packed {
        logic short_route;
        logic improve;
        logic j_more;
        logic i_more;
        logic pass_more;
        logic flip_more;
        logic out_last;
    } status_t;

endpackage

// ===== rtl/tor_ram.sv =====
// ----------------------------------------------------------------------------
// tor_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tor_ctrl.sv =====
// ----------------------------------------------------------------------------
// tor_ctrl
// Sequencer: loads, pair scan, segment reversal and route read-out.
// ----------------------------------------------------------------------------
module tor_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mode,
    input  logic             route_end,
    input  tor_pkg::status_t status,
    output tor_pkg::cmd_t    cmd,
    output logic             busy
);

    tor_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tor_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tor_pkg::ST_IDLE:
            begin
                if (start && mode && route_end)
                begin
                    state_next = tor_pkg::ST_CHECK;
                end
            end
            tor_pkg::ST_CHECK:
                state_next = status.short_route ? tor_pkg::ST_OPRIME : tor_pkg::ST_RP;
            tor_pkg::ST_RP:  state_next = tor_pkg::ST_RA;
            tor_pkg::ST_RA:  state_next = tor_pkg::ST_RB;
            tor_pkg::ST_RB:  state_next = tor_pkg::ST_RQ;
            tor_pkg::ST_RQ:  state_next = tor_pkg::ST_DPA;
            tor_pkg::ST_DPA: state_next = tor_pkg::ST_DBQ;
            tor_pkg::ST_DBQ: state_next = tor_pkg::ST_DPB;
            tor_pkg::ST_DPB: state_next = tor_pkg::ST_DAQ;
            tor_pkg::ST_DAQ: state_next = tor_pkg::ST_CMP;
            tor_pkg::ST_CMP:
                state_next = status.improve ? tor_pkg::ST_FRL : tor_pkg::ST_ADV;
            tor_pkg::ST_FRL: state_next = tor_pkg::ST_FRH;
            tor_pkg::ST_FRH: state_next = tor_pkg::ST_FWL;
            tor_pkg::ST_FWL: state_next = tor_pkg::ST_FWH;
            tor_pkg::ST_FWH:
                state_next = status.flip_more ? tor_pkg::ST_FRL : tor_pkg::ST_ADV;
            tor_pkg::ST_ADV:
            begin
                if (status.j_more || status.i_more || status.pass_more)
                begin
                    state_next = tor_pkg::ST_RP;
                end
                else
                begin
                    state_next = tor_pkg::ST_OPRIME;
                end
            end
            tor_pkg::ST_OPRIME: state_next = tor_pkg::ST_ORUN;
            tor_pkg::ST_ORUN:
                state_next = status.out_last ? tor_pkg::ST_IDLE : tor_pkg::ST_ORUN;
            default: state_next = tor_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.rsel = tor_pkg::RA_PM1;
        cmd.dsel = tor_pkg::DA_PA;
        busy     = (state_reg != tor_pkg::ST_IDLE);
        case (state_reg)
            tor_pkg::ST_IDLE:
            begin
                cmd.load_dist  = start && !mode;
                cmd.load_route = start && mode;
            end
            tor_pkg::ST_CHECK: cmd.init_pass = 1'b1;
            tor_pkg::ST_RP:    cmd.rsel = tor_pkg::RA_PM1;
            tor_pkg::ST_RA:
            begin
                cmd.rsel  = tor_pkg::RA_I;
                cmd.cap_p = 1'b1;
            end
            tor_pkg::ST_RB:
            begin
                cmd.rsel  = tor_pkg::RA_J;
                cmd.cap_a = 1'b1;
            end
            tor_pkg::ST_RQ:
            begin
                cmd.rsel  = tor_pkg::RA_JP1;
                cmd.cap_b = 1'b1;
            end
            tor_pkg::ST_DPA:
            begin
                cmd.cap_q = 1'b1;
                cmd.dsel  = tor_pkg::DA_PA;
            end
            tor_pkg::ST_DBQ:
            begin
                cmd.dsel      = tor_pkg::DA_BQ;
                cmd.now_first = 1'b1;
            end
            tor_pkg::ST_DPB:
            begin
                cmd.dsel    = tor_pkg::DA_PB;
                cmd.now_add = 1'b1;
            end
            tor_pkg::ST_DAQ:
            begin
                cmd.dsel      = tor_pkg::DA_AQ;
                cmd.alt_first = 1'b1;
            end
            tor_pkg::ST_CMP:   cmd.set_flip = status.improve;
            tor_pkg::ST_FRL:   cmd.rsel = tor_pkg::RA_LO;
            tor_pkg::ST_FRH:
            begin
                cmd.rsel  = tor_pkg::RA_HI;
                cmd.cap_t = 1'b1;
            end
            tor_pkg::ST_FWL:   cmd.wr_lo = 1'b1;
            tor_pkg::ST_FWH:   cmd.wr_hi_step = 1'b1;
            tor_pkg::ST_ADV:
            begin
                // priority: inner index, outer index, then a fresh pass
                if (status.j_more)
                begin
                    cmd.next_j = 1'b1;
                end
                else if (status.i_more)
                begin
                    cmd.next_i = 1'b1;
                end
                else
                begin
                    cmd.next_pass = 1'b1;
                end
            end
            tor_pkg::ST_OPRIME:
            begin
                cmd.out_init = 1'b1;
                cmd.rsel     = tor_pkg::RA_ZERO;
            end
            tor_pkg::ST_ORUN:
            begin
                cmd.out_emit = 1'b1;
                cmd.rsel     = tor_pkg::RA_K1;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== rtl/tor_dpath.sv =====
// ----------------------------------------------------------------------------
// tor_dpath
// Route and distance stores, pair indices, edge sums and output register.
// ----------------------------------------------------------------------------
module tor_dpath #(
    parameter int NODE_COUNT = 256,
    parameter int MAX_ROUTE  = 16,
    parameter int DIST_BITS  = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tor_pkg::cmd_t    cmd,
    input  logic [7:0]       row_node,
    input  logic [7:0]       to_node,
    input  logic [23:0]      distance_value,
    input  logic [7:0]       route_node,
    output tor_pkg::status_t status,
    output logic             out_valid,
    output logic [7:0]       out_node,
    output logic             out_last
);

    localparam int IW = $clog2(MAX_ROUTE);
    localparam int CW = $clog2(MAX_ROUTE + 1);
    localparam int DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int AW = $clog2(DEPTH);
    localparam int SW = DIST_BITS + 1;

    function automatic logic in_range(input logic [7:0] n);
        in_range = (int'(n) < NODE_COUNT);
    endfunction

    function automatic logic [AW-1:0] dist_addr(input logic [7:0] x, input logic [7:0] y);
        dist_addr = AW'(int'(x) * NODE_COUNT + int'(y));
    endfunction

    logic [CW-1:0] len_reg;
    logic [IW-1:0] i_reg, j_reg, lo_reg, hi_reg;
    logic [CW-1:0] k_reg;
    logic [tor_pkg::PASS_W-1:0] pass_reg;
    logic changed_reg;
    logic [7:0] p_reg, a_reg, b_reg, q_reg, t_reg;
    logic [SW-1:0] now_reg, alt_reg;
    logic dok_reg;
    logic out_valid_reg, out_last_reg;
    logic [7:0] out_node_reg;

    logic [IW-1:0] r_raddr, r_waddr;
    logic [7:0] r_wdata, r_rdata;
    logic r_we;
    logic [AW-1:0] d_raddr;
    logic [DIST_BITS-1:0] d_rdata, d_wdata, dval;
    logic [7:0] dx, dy;
    logic [47:0] wide_v, dmax;
    logic [SW-1:0] alt_sum;

    // ---- route store ----
    always_comb
    begin
        case (cmd.rsel)
            tor_pkg::RA_PM1:  r_raddr = i_reg - 1'b1;
            tor_pkg::RA_I:    r_raddr = i_reg;
            tor_pkg::RA_J:    r_raddr = j_reg;
            tor_pkg::RA_JP1:  r_raddr = j_reg + 1'b1;
            tor_pkg::RA_LO:   r_raddr = lo_reg;
            tor_pkg::RA_HI:   r_raddr = hi_reg;
            tor_pkg::RA_ZERO: r_raddr = '0;
            tor_pkg::RA_K1:   r_raddr = k_reg[IW-1:0] + 1'b1;
            default:          r_raddr = '0;
        endcase
        r_we    = 1'b0;
        r_waddr = len_reg[IW-1:0];
        r_wdata = route_node;
        if (cmd.load_route)
        begin
            r_we = (int'(len_reg) < MAX_ROUTE);
        end
        else if (cmd.wr_lo)
        begin
            r_we    = 1'b1;
            r_waddr = lo_reg;
            r_wdata = r_rdata;
        end
        else if (cmd.wr_hi_step)
        begin
            r_we    = 1'b1;
            r_waddr = hi_reg;
            r_wdata = t_reg;
        end
    end

    tor_ram #(.WIDTH(8), .DEPTH(MAX_ROUTE)) u_route (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // ---- distance store ----
    always_comb
    begin
        case (cmd.dsel)
            tor_pkg::DA_PA: begin dx = p_reg; dy = a_reg; end
            tor_pkg::DA_BQ: begin dx = b_reg; dy = q_reg; end
            tor_pkg::DA_PB: begin dx = p_reg; dy = b_reg; end
            tor_pkg::DA_AQ: begin dx = a_reg; dy = q_reg; end
            default:        begin dx = p_reg; dy = a_reg; end
        endcase
        d_raddr = dist_addr(dx, dy);
        wide_v  = {24'b0, distance_value};
        dmax    = {48{1'b1}} >> (48 - DIST_BITS);
        d_wdata = (wide_v > dmax) ? dmax[DIST_BITS-1:0] : wide_v[DIST_BITS-1:0];
        dval    = dok_reg ? d_rdata : '0;
        alt_sum = alt_reg + SW'(dval);
    end

    tor_ram #(.WIDTH(DIST_BITS), .DEPTH(DEPTH)) u_dist (
        .clk   (clk),
        .we    (cmd.load_dist && in_range(row_node) && in_range(to_node)),
        .waddr (dist_addr(row_node, to_node)),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // ---- status ----
    always_comb
    begin
        status.short_route = (len_reg <= CW'(tor_pkg::SHORT_ROUTE));
        status.improve     = (alt_sum < now_reg);
        status.j_more      = (CW'(j_reg) + 1'b1) < (len_reg - 1'b1);
        status.i_more      = (CW'(i_reg) + 1'b1) < (len_reg - 2'd2);
        status.pass_more   = changed_reg
                             && (int'(pass_reg) + 1 < tor_pkg::PASS_LIMIT);
        status.flip_more   = (CW'(lo_reg) + 2'd2) < CW'(hi_reg);
        status.out_last    = (k_reg + 1'b1) == len_reg;
    end

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_route && (int'(len_reg) < MAX_ROUTE))
            begin
                len_reg <= len_reg + 1'b1;
            end
            else if (cmd.out_emit && status.out_last)
            begin
                len_reg <= '0;
            end
            out_valid_reg <= cmd.out_emit;
        end
    end

    // ---- working registers ----
    always_ff @(posedge clk)
    begin
        dok_reg <= in_range(dx) && in_range(dy);
        if (cmd.init_pass || cmd.next_pass)
        begin
            i_reg       <= IW'(1);
            j_reg       <= IW'(2);
            changed_reg <= 1'b0;
            pass_reg    <= cmd.init_pass ? '0 : pass_reg + 1'b1;
        end
        if (cmd.next_j)
        begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.next_i)
        begin
            i_reg <= i_reg + 1'b1;
            j_reg <= i_reg + 2'd2;
        end
        if (cmd.cap_p) p_reg <= r_rdata;
        if (cmd.cap_a) a_reg <= r_rdata;
        if (cmd.cap_b) b_reg <= r_rdata;
        if (cmd.cap_q) q_reg <= r_rdata;
        if (cmd.cap_t) t_reg <= r_rdata;
        if (cmd.now_first) now_reg <= SW'(dval);
        if (cmd.now_add)   now_reg <= now_reg + SW'(dval);
        if (cmd.alt_first) alt_reg <= SW'(dval);
        if (cmd.set_flip)
        begin
            lo_reg      <= i_reg;
            hi_reg      <= j_reg;
            changed_reg <= 1'b1;
        end
        if (cmd.wr_hi_step)
        begin
            lo_reg <= lo_reg + 1'b1;
            hi_reg <= hi_reg - 1'b1;
        end
        if (cmd.out_init)
        begin
            k_reg <= '0;
        end
        if (cmd.out_emit)
        begin
            k_reg        <= k_reg + 1'b1;
            out_node_reg <= r_rdata;
            out_last_reg <= status.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_node  = out_node_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/two_opt_route_improver.sv =====
// Load items (distance entry or route node) are taken in the idle state; busy stays low.
// Route end: a setup check, then per pair i<j route reads, distance reads and a compare,
// plus swaps of node pairs on a reversal, repeated per pass (up to 256 passes), then
// read-out; the route and distance RAMs each have one read port. Results: n words on
// consecutive cycles. Async reset clears route length and control; stores keep data.
// ----------------------------------------------------------------------------
// two_opt_route_improver
// 2-opt first-improvement route search over a loaded distance matrix.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_opt_route_improver #(
    parameter int NODE_COUNT = 256,
    parameter int MAX_ROUTE  = 16,
    parameter int DIST_BITS  = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  row_node,
    input  logic [7:0]  to_node,
    input  logic [23:0] distance_value,
    input  logic [7:0]  route_node,
    input  logic        route_end,
    output logic        out_valid,
    output logic [7:0]  out_node,
    output logic        out_last
);

    tor_pkg::cmd_t    cmd;
    tor_pkg::status_t status;

    tor_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .route_end (route_end),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    tor_dpath #(
        .NODE_COUNT (NODE_COUNT),
        .MAX_ROUTE  (MAX_ROUTE),
        .DIST_BITS  (DIST_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .row_node       (row_node),
        .to_node        (to_node),
        .distance_value (distance_value),
        .route_node     (route_node),
        .status         (status),
        .out_valid      (out_valid),
        .out_node       (out_node),
        .out_last       (out_last)
    );

    `ASSERT_CLK(a_no_word_after_accept, clk, rst_n, (start && !busy) |=> !out_valid, "word right after accept")
    `ASSERT_CLK(a_last_ends_burst, clk, rst_n, (out_valid && out_last) |=> !out_valid, "word after last")
    `ASSERT_CLK(a_burst_contiguous, clk, rst_n, (out_valid && !out_last) |=> out_valid, "gap in route burst")

endmodule
